@@ rtl/lsbp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsbp_pkg
// Shared types and constants of the lsb-first bit packer: field widths,
// the queue entry that carries one classified item to the output side,
// and the queue status bundle.
// ----------------------------------------------------------------------------
package lsbp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;
  localparam int unsigned FillW  = 3;

  localparam logic [CountW-1:0] FullBits = 4'd8;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // one item's worth of output work: an optional full byte followed by an
  // optional zero-padded partial byte
  typedef struct packed {
    logic              has_full;
    logic [ByteW-1:0]  full_byte;
    logic              full_final;
    logic              has_part;
    logic [ByteW-1:0]  part_byte;
    logic [CountW-1:0] part_bits;
  } lsbp_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } lsbp_q_status_t;

endpackage

@@ rtl/lsb_first_bit_packer_core.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core
// Packs fields of 0 to 8 bits, least significant bit first, into bytes.
// ----------------------------------------------------------------------------
// The block accepts one field per clock cycle while in_stall is low and emits
// at most one byte per cycle. An item is merged into the partial byte in the
// cycle it is accepted; the resulting full and flushed bytes pass through a
// four-entry queue to the output register, so each byte is registered in a
// queue slot and then in the output register. An item that yields a full byte
// and a flushed partial byte puts two bytes on the single output port, so the
// sustained rate is one item per cycle only while items average at most
// one byte each; the queue absorbs short bursts, and in_stall rises when it
// is full. Bits of data_bits at or above bit_count are ignored, counts above
// eight act as eight, and end_of_stream flushes the pending bits zero-padded
// with final_res set on the last byte of the stream.
module lsb_first_bit_packer_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsbp_pkg::ByteW-1:0]   data_bits,
  input  logic [lsbp_pkg::CountW-1:0]  bit_count,
  input  logic                         end_of_stream,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsbp_pkg::ByteW-1:0]   out_byte,
  output logic [lsbp_pkg::CountW-1:0]  valid_bits,
  output logic                         final_res
);
  import lsbp_pkg::*;

  logic           accept;
  logic           push;
  logic           pop;
  lsbp_entry_t    wr_entry;
  lsbp_entry_t    head;
  lsbp_q_status_t q_stat;

  // input handshake
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  lsbp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_bits     (data_bits),
    .bit_count     (bit_count),
    .end_of_stream (end_of_stream),
    .entry         (wr_entry),
    .push          (push)
  );

  lsbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .status   (q_stat)
  );

  lsbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_stat.empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .valid_bits (valid_bits),
    .final_res  (final_res)
  );

  // output byte always carries one to eight meaningful bits
  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bits != '0) && (valid_bits <= FullBits))
    else $error("valid_bits out of range");

  // a partial byte only ever comes from a flush
  a_part_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && (valid_bits != FullBits) |-> final_res)
    else $error("partial byte without final mark");

  // nothing leaves the queue while it is empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("queue pop while empty");

  // output register is clear straight after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

@@ rtl/lsbp_front.sv @@
// ----------------------------------------------------------------------------
// lsbp_front
// Input side: merges each field into the pending partial byte, splits off
// a completed byte and a flushed remainder, and hands them on as one entry.
// ----------------------------------------------------------------------------
module lsbp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [lsbp_pkg::ByteW-1:0]   data_bits,
  input  logic [lsbp_pkg::CountW-1:0]  bit_count,
  input  logic                         end_of_stream,
  output lsbp_pkg::lsbp_entry_t        entry,
  output logic                         push
);
  import lsbp_pkg::*;

  logic [ByteW-1:0]    pend_byte;
  logic [FillW-1:0]    pend_cnt;
  logic [ByteW-1:0]    pend_byte_next;
  logic [FillW-1:0]    pend_cnt_next;

  logic [CountW-1:0]   cnt_sat;
  logic [ByteW-1:0]    data_m;
  logic [2*ByteW-1:0]  acc;
  logic [CountW-1:0]   total;
  logic                is_full;
  logic [ByteW-1:0]    rem_byte;
  logic [CountW-1:0]   rem_bits;

  // saturate the count and clear stray data bits
  always_comb begin
    cnt_sat = (bit_count > FullBits) ? FullBits : bit_count;
    for (int i = 0; i < ByteW; i++) begin
      data_m[i] = data_bits[i] && (CountW'(i) < cnt_sat);
    end
  end

  // merge into the partial byte and split
  always_comb begin
    acc      = {{ByteW{1'b0}}, pend_byte} | ({{ByteW{1'b0}}, data_m} << pend_cnt);
    total    = {1'b0, pend_cnt} + cnt_sat;
    is_full  = (total >= FullBits);
    rem_byte = is_full ? acc[2*ByteW-1:ByteW] : acc[ByteW-1:0];
    rem_bits = is_full ? (total - FullBits) : total;
  end

  // classify the item
  always_comb begin
    entry.has_full   = is_full;
    entry.full_byte  = acc[ByteW-1:0];
    entry.full_final = end_of_stream && (rem_bits == '0);
    entry.has_part   = end_of_stream && (rem_bits != '0);
    entry.part_byte  = rem_byte;
    entry.part_bits  = rem_bits;
    push = accept && (entry.has_full || entry.has_part);
  end

  // next partial state, cleared by a flush
  always_comb begin
    if (end_of_stream) begin
      pend_byte_next = '0;
      pend_cnt_next  = '0;
    end else begin
      pend_byte_next = rem_byte;
      pend_cnt_next  = rem_bits[FillW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_byte <= '0;
      pend_cnt  <= '0;
    end else if (accept) begin
      pend_byte <= pend_byte_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

endmodule

@@ rtl/lsbp_queue.sv @@
// ----------------------------------------------------------------------------
// lsbp_queue
// Short first-in first-out queue of classified entries between the input
// side and the output side.
// ----------------------------------------------------------------------------
module lsbp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  lsbp_pkg::lsbp_entry_t  wr_entry,
  input  logic                   pop,
  output lsbp_pkg::lsbp_entry_t  rd_entry,
  output lsbp_pkg::lsbp_q_status_t status
);
  import lsbp_pkg::*;

  lsbp_entry_t      slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] fill;

  // status flags
  always_comb begin
    status.empty = (fill == '0);
    status.full  = (fill == QCntW'(QDepth));
    rd_entry     = slots[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ rtl/lsbp_back.sv @@
// ----------------------------------------------------------------------------
// lsbp_back
// Output side: expands each queued entry into one or two bytes and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module lsbp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  lsbp_pkg::lsbp_entry_t        head,
  input  logic                         head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsbp_pkg::ByteW-1:0]   out_byte,
  output logic [lsbp_pkg::CountW-1:0]  valid_bits,
  output logic                         final_res
);
  import lsbp_pkg::*;

  logic              full_sent;
  logic              load;
  logic              take_full;
  logic [ByteW-1:0]  byte_next;
  logic [CountW-1:0] bits_next;
  logic              final_next;

  // pick the next byte of the head entry
  always_comb begin
    load       = head_valid && (!out_valid || !out_stall);
    take_full  = head.has_full && !full_sent;
    byte_next  = take_full ? head.full_byte : head.part_byte;
    bits_next  = take_full ? FullBits : head.part_bits;
    final_next = take_full ? head.full_final : 1'b1;
    pop        = load && !(take_full && head.has_part);
  end

  // output register and expansion phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        full_sent <= take_full && head.has_part;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= byte_next;
      valid_bits <= bits_next;
      final_res  <= final_next;
    end
  end

endmodule

@@ tb/lsb_first_bit_packer_core_tb.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_core_tb
// Self-checking bench for the lsb-first bit packer. Fields are offered on the
// input channel and every packed byte leaving the block is compared against
// a bit-accurate packing model held in a small scoreboard. Both channels idle
// at random, the output is held off for a long stretch to fill the internal
// queue, and a watchdog ends the run if traffic stops.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 80;
  localparam int StallLimit = 1000;
  localparam int TailCycles = 10;

  typedef struct packed {
    logic [7:0] octet;
    logic [3:0] nbits;
    logic       last;
  } packed_octet_t;

  // packing model and store of bytes still due from the block
  class pack_scoreboard;
    packed_octet_t due_q[$];
    logic [7:0]    part_byte;
    logic [2:0]    part_fill;
    int            errors;
    int            fields;
    int            checked;
    int            flushes;

    function new();
      part_byte = 8'h00;
      part_fill = 3'd0;
      errors    = 0;
      fields    = 0;
      checked   = 0;
      flushes   = 0;
    endfunction

    // merge one accepted field and queue the bytes it completes
    function void note_field(logic [7:0] d, logic [3:0] c, logic e);
      logic [3:0]    take;
      logic [15:0]   held;
      logic [15:0]   fresh;
      logic [15:0]   acc;
      logic [4:0]    total;
      logic          have_full;
      packed_octet_t full_rec;
      packed_octet_t part_rec;
      take  = (c > 4'd8) ? 4'd8 : c;
      fresh = 16'(d) & ((16'h0001 << take) - 16'h0001);
      held  = 16'(part_byte) & ((16'h0001 << part_fill) - 16'h0001);
      acc   = held | (fresh << part_fill);
      total = 5'(part_fill) + 5'(take);
      have_full = (total >= 5'd8);
      full_rec.octet = acc[7:0];
      full_rec.nbits = 4'd8;
      full_rec.last  = 1'b0;
      if (have_full) begin
        acc   = acc >> 8;
        total = total - 5'd8;
      end
      // a flush with no partial bits marks the full byte of this step instead
      if (e && total == 5'd0 && have_full) full_rec.last = 1'b1;
      if (have_full) due_q.push_back(full_rec);
      if (e && total != 5'd0) begin
        part_rec.octet = acc[7:0];
        part_rec.nbits = total[3:0];
        part_rec.last  = 1'b1;
        due_q.push_back(part_rec);
      end
      if (e) begin
        acc   = 16'h0000;
        total = 5'd0;
        flushes++;
      end
      part_byte = acc[7:0];
      part_fill = total[2:0];
      fields++;
    endfunction

    // compare one emitted byte with the oldest one due
    function void check_byte(logic [7:0] b, logic [3:0] n, logic f);
      packed_octet_t want;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected byte %h bits %0d final %b", $time, b, n, f);
        errors++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (b !== want.octet) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.octet, b);
        errors++;
      end
      if (n !== want.nbits) begin
        $display("%0t: valid_bits expected %0d actual %0d", $time, want.nbits, n);
        errors++;
      end
      if (f !== want.last) begin
        $display("%0t: final_res expected %b actual %b", $time, want.last, f);
        errors++;
      end
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_bits;
  logic [3:0] bit_count;
  logic       end_of_stream;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [3:0] valid_bits;
  logic       final_res;

  pack_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_reqs;
  int holds_done;
  int hold_left;
  int quiet_cycles;

  lsb_first_bit_packer_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_bits     (data_bits),
    .bit_count     (bit_count),
    .end_of_stream (end_of_stream),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .valid_bits    (valid_bits),
    .final_res     (final_res)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_field(data_bits, bit_count, end_of_stream);
      if (out_valid && !out_stall) sb.check_byte(out_byte, valid_bits, final_res);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog on stalled traffic
  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk);
    $display("lsb_first_bit_packer_core verification failed");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked for
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // offer one field and wait for its transaction
  task automatic offer_field(input logic [7:0] d, input logic [3:0] c, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    data_bits     <= d;
    bit_count     <= c;
    end_of_stream <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering until every byte due has left the block
  task automatic drain_bytes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // random streams: mostly legal counts, some oversized or empty fields
  task automatic send_random_fields(input int n);
    int         sent;
    int         r;
    logic [3:0] c;
    logic       e;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(99);
      if (r < 8) c = 4'($urandom_range(15, 9));
      else if (r < 13) c = 4'd0;
      else c = 4'($urandom_range(8, 1));
      e = ($urandom_range(7) == 0);
      offer_field(8'($urandom_range(255)), c, e);
      if (c != 4'd0 || e) sent++;
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    in_valid      = 1'b0;
    data_bits     = 8'h00;
    bit_count     = 4'd0;
    end_of_stream = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 48;
    hold_reqs     = 0;
    holds_done    = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty fields, extremes, stray bits, oversized counts, flushes
    offer_field(8'hff, 4'd0, 1'b0);
    offer_field(8'hff, 4'd0, 1'b1);
    offer_field(8'hff, 4'd8, 1'b0);
    offer_field(8'h00, 4'd8, 1'b0);
    offer_field(8'hff, 4'd3, 1'b0);
    offer_field(8'ha5, 4'd5, 1'b0);
    offer_field(8'h5a, 4'd15, 1'b0);
    offer_field(8'hc3, 4'd9, 1'b0);
    offer_field(8'h01, 4'd1, 1'b1);
    offer_field(8'h7f, 4'd7, 1'b0);
    offer_field(8'hfe, 4'd4, 1'b1);
    offer_field(8'h0a, 4'd4, 1'b0);
    offer_field(8'hf5, 4'd4, 1'b1);
    offer_field(8'h35, 4'd6, 1'b0);
    offer_field(8'hff, 4'd0, 1'b1);
    offer_field(8'h80, 4'd8, 1'b1);
    offer_field(8'h1f, 4'd5, 1'b0);
    offer_field(8'hc3, 4'd12, 1'b1);
    offer_field(8'h00, 4'd7, 1'b0);
    offer_field(8'hff, 4'd8, 1'b1);
    offer_field(8'h55, 4'd2, 1'b1);
    drain_bytes();

    // sender idles lightly, receiver heavily
    send_random_fields(150);
    hold_reqs++;
    send_random_fields(24);
    drain_bytes();
    send_random_fields(140);

    // roles swapped
    send_idle_pct = 48;
    recv_idle_pct = 24;
    send_random_fields(310);

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_fields(310);

    drain_bytes();
    repeat (TailCycles) @(posedge clk);

    $display("run covered %0d field transactions and %0d stream flushes,", sb.fields,
             sb.flushes);
    $display("with %0d packed bytes checked and %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("lsb_first_bit_packer_core verification clean");
    end else begin
      $display("lsb_first_bit_packer_core verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/lsbp_pkg.sv
rtl/lsbp_front.sv
rtl/lsbp_queue.sv
rtl/lsbp_back.sv
rtl/lsb_first_bit_packer_core.sv
tb/lsb_first_bit_packer_core_tb.sv
